[sv/assert_macros.svh]
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checks that one condition is followed by another at the next edge.
`define ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

[sv/bfba_pkg.sv]
// Package with the types, constants and helpers of the best-fit block allocator.
`timescale 1ns / 1ps
`default_nettype none
package bfba_pkg;

   localparam int MAX_BLOCKS = 16;
   localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int SIZE_W = 16;
   localparam int OWNER_W = 8;
   localparam int BIDX_W = 4;
   localparam int STATUS_W = 3;

   typedef enum logic [0:0] {
      OP_LOAD  = 1'b0,
      OP_ALLOC = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_LOADED       = 3'd0,
      ST_LOAD_INVALID = 3'd1,
      ST_TABLE_FULL   = 3'd2,
      ST_ALLOCATED    = 3'd3,
      ST_NO_FIT       = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_TAIL,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [SIZE_W-1:0]  start;
      logic [SIZE_W-1:0]  size;
      logic               busy;
      logic [OWNER_W-1:0] owner;
   } entry_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      entry_type        wdata;
      logic             re;
      logic [IDX_W-1:0] raddr;
   } ram_cmd_type;

   typedef struct packed {
      status_type        status;
      logic [BIDX_W-1:0] block_index;
      logic [SIZE_W-1:0] block_start;
      logic [SIZE_W-1:0] block_end;
   } result_type;

   function automatic logic [BIDX_W-1:0] to_block_index(input logic [IDX_W-1:0] idx);
      logic [IDX_W+BIDX_W-1:0] wide;
      wide = {{BIDX_W{1'b0}}, idx};
      return wide[BIDX_W-1:0];
   endfunction

endpackage
`default_nettype wire

[sv/bfba_ram.sv]
// Single-port-write, single-port-read RAM with a registered read, used for the block table.
`timescale 1ns / 1ps
`default_nettype none
module bfba_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

[sv/bfba_ctrl.sv]
// Sequencer that loads blocks, scans the table for the best fit and writes back the choice.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bfba_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       req_op,
   input  wire logic [15:0]                req_item_size,
   input  wire logic                       req_occupied,
   input  wire logic [7:0]                 req_owner_id,
   input  wire logic [15:0]                memory_total,
   output logic                            res_valid,
   output bfba_pkg::result_type            res,
   input  wire logic                       out_free,
   output bfba_pkg::ram_cmd_type           ram_cmd,
   input  wire bfba_pkg::entry_type        ram_rdata
);
   import bfba_pkg::*;

   state_type           state_ff, state_in;
   op_type              op_ff, op_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [OWNER_W-1:0]  owner_ff, owner_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [SIZE_W-1:0]   next_start_ff, next_start_in;
   logic [IDX_W-1:0]    ptr_ff, ptr_in;
   logic                eval_vld_ff, eval_vld_in;
   logic [IDX_W-1:0]    eval_idx_ff, eval_idx_in;
   logic                found_ff, found_in;
   logic [IDX_W-1:0]    best_idx_ff, best_idx_in;
   logic [SIZE_W-1:0]   best_waste_ff, best_waste_in;
   logic [SIZE_W-1:0]   best_start_ff, best_start_in;
   logic [SIZE_W-1:0]   best_size_ff, best_size_in;
   status_type          ld_status_ff, ld_status_in;
   entry_type           ld_entry_ff, ld_entry_in;

   logic                accept;
   logic [SIZE_W:0]     load_sum;
   logic [SIZE_W-1:0]   waste;
   logic                fits;
   logic [SIZE_W-1:0]   ld_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         next_start_ff <= '0;
         eval_vld_ff <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         next_start_ff <= next_start_in;
         eval_vld_ff <= eval_vld_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      size_ff <= size_in;
      owner_ff <= owner_in;
      ptr_ff <= ptr_in;
      eval_idx_ff <= eval_idx_in;
      best_idx_ff <= best_idx_in;
      best_waste_ff <= best_waste_in;
      best_start_ff <= best_start_in;
      best_size_ff <= best_size_in;
      ld_status_ff <= ld_status_in;
      ld_entry_ff <= ld_entry_in;
   end

   assign load_sum = {1'b0, next_start_ff} + {1'b0, req_item_size};
   assign waste = ram_rdata.size - size_ff;
   assign fits = !ram_rdata.busy && (ram_rdata.size >= size_ff);
   assign ld_end = ld_entry_ff.start + ld_entry_ff.size;

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      size_in = size_ff;
      owner_in = owner_ff;
      count_in = count_ff;
      next_start_in = next_start_ff;
      ptr_in = ptr_ff;
      eval_vld_in = 1'b0;
      eval_idx_in = ptr_ff;
      found_in = found_ff;
      best_idx_in = best_idx_ff;
      best_waste_in = best_waste_ff;
      best_start_in = best_start_ff;
      best_size_in = best_size_ff;
      ld_status_in = ld_status_ff;
      ld_entry_in = ld_entry_ff;
      req_stall = 1'b1;
      accept = 1'b0;
      res_valid = 1'b0;
      res = '{status: ST_NO_FIT, block_index: '0, block_start: '0, block_end: '0};
      ram_cmd = '{we: 1'b0, waddr: '0, wdata: '0, re: 1'b0, raddr: ptr_ff};

      if (eval_vld_ff && fits && (!found_ff || waste < best_waste_ff)) begin
         found_in = 1'b1;
         best_idx_in = eval_idx_ff;
         best_waste_in = waste;
         best_start_in = ram_rdata.start;
         best_size_in = ram_rdata.size;
      end

      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            accept = req_valid;
            if (accept) begin
               op_in = op_type'(req_op);
               size_in = req_item_size;
               owner_in = req_owner_id;
               ptr_in = '0;
               found_in = 1'b0;
               if (req_item_size == '0 || load_sum > {1'b0, memory_total}) begin
                  ld_status_in = ST_LOAD_INVALID;
               end else if (count_ff == CNT_W'(MAX_BLOCKS)) begin
                  ld_status_in = ST_TABLE_FULL;
               end else begin
                  ld_status_in = ST_LOADED;
               end
               ld_entry_in = '{start: next_start_ff, size: req_item_size, busy: req_occupied,
                               owner: req_occupied ? req_owner_id : '0};
               if (op_type'(req_op) == OP_ALLOC && count_ff != '0) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_SCAN: begin
            ram_cmd.re = 1'b1;
            eval_vld_in = 1'b1;
            ptr_in = ptr_ff + IDX_W'(1);
            if (CNT_W'(ptr_ff) + CNT_W'(1) == count_ff) begin
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            res_valid = 1'b1;
            if (op_ff == OP_LOAD) begin
               res.status = ld_status_ff;
               if (ld_status_ff == ST_LOADED) begin
                  res.block_index = to_block_index(count_ff[IDX_W-1:0]);
                  res.block_start = ld_entry_ff.start;
                  res.block_end = ld_end;
                  ram_cmd.we = 1'b1;
                  ram_cmd.waddr = count_ff[IDX_W-1:0];
                  ram_cmd.wdata = ld_entry_ff;
               end
            end else if (found_ff) begin
               res.status = ST_ALLOCATED;
               res.block_index = to_block_index(best_idx_ff);
               res.block_start = best_start_ff;
               res.block_end = best_start_ff + best_size_ff;
               ram_cmd.we = 1'b1;
               ram_cmd.waddr = best_idx_ff;
               ram_cmd.wdata = '{start: best_start_ff, size: best_size_ff, busy: 1'b1,
                                 owner: owner_ff};
            end
            if (out_free) begin
               state_in = S_IDLE;
               if (op_ff == OP_LOAD && ld_status_ff == ST_LOADED) begin
                  count_in = count_ff + CNT_W'(1);
                  next_start_in = ld_end;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `ASSERT_CLK(a_count_bound, count_ff <= CNT_W'(MAX_BLOCKS), "block count above table depth")
   `ASSERT_CLK(a_no_rw_overlap, !(ram_cmd.we && ram_cmd.re), "table read and write overlap")
   `ASSERT_CLK(a_best_in_table, !found_ff || CNT_W'(best_idx_ff) < count_ff,
      "best fit index outside loaded blocks")
   `ASSERT_NEXT(a_load_grows, res_valid && out_free && op_ff == OP_LOAD &&
      ld_status_ff == ST_LOADED, count_ff == $past(count_ff) + CNT_W'(1),
      "load did not advance block count")

endmodule
`default_nettype wire

[sv/best_fit_block_allocator_core.sv]
// Top level of the best-fit block allocator: register, table memory, sequencer and output stage.
// A load, or an allocate on an empty table, goes from the idle state straight to the finish state.
// An allocate on a table of N blocks, at most MAX_BLOCKS, passes through the scan, tail and finish
// states, with a one-entry-per-cycle scan of the table memory; the next item waits for idle.
// The output register holds a result while the next item is accepted and worked on.
// Synchronous reset empties the table, clears the start address and sets the total to 65535.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module best_fit_block_allocator_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_op,
   input  wire logic [15:0] req_item_size,
   input  wire logic        req_occupied,
   input  wire logic [7:0]  req_owner_id,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [3:0]       rsp_block_index,
   output logic [15:0]      rsp_block_start,
   output logic [15:0]      rsp_block_end,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);
   import bfba_pkg::*;

   logic [SIZE_W-1:0] total_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff;
   logic              res_valid;
   result_type        res;
   logic              out_free;
   ram_cmd_type       ram_cmd;
   entry_type         ram_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= 16'hFFFF;
      end else if (csr_wr_en) begin
         total_ff <= csr_wr_data;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && out_free) begin
         rsp_ff <= res;
      end
   end

   bfba_ram #(
      .DEPTH (MAX_BLOCKS),
      .WIDTH ($bits(entry_type))
   ) u_ram (
      .clock (clock),
      .we    (ram_cmd.we),
      .waddr (ram_cmd.waddr),
      .wdata (ram_cmd.wdata),
      .re    (ram_cmd.re),
      .raddr (ram_cmd.raddr),
      .rdata (ram_rdata)
   );

   bfba_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_item_size (req_item_size),
      .req_occupied  (req_occupied),
      .req_owner_id  (req_owner_id),
      .memory_total  (total_ff),
      .res_valid     (res_valid),
      .res           (res),
      .out_free      (out_free),
      .ram_cmd       (ram_cmd),
      .ram_rdata     (ram_rdata)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_ff.status;
   assign rsp_block_index = rsp_ff.block_index;
   assign rsp_block_start = rsp_ff.block_start;
   assign rsp_block_end = rsp_ff.block_end;

   `ASSERT_NEXT(a_rsp_loaded, res_valid && out_free, rsp_valid_ff,
      "finished item not shown at the output")
   `ASSERT_CLK(a_no_fit_zero, !rsp_valid_ff || rsp_ff.status != ST_NO_FIT ||
      (rsp_ff.block_start == '0 && rsp_ff.block_end == '0), "no fit result carries an address")

endmodule
`default_nettype wire
